@@ rtl/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// csc_pkg: shared types for the color space converter
// Color space codes, the channel bundle of one pixel and the space selector.
// ----------------------------------------------------------------------------
package csc_pkg;

  // Color space codes as carried on the selector fields
  typedef enum logic [1:0] {
    SPACE_GREY = 2'd0,
    SPACE_RGB  = 2'd1,
    SPACE_RGBA = 2'd2,
    SPACE_YUV  = 2'd3
  } space_t;

  // Four 8-bit channels, c0 in the lowest bits
  typedef struct packed {
    logic [7:0] c3;
    logic [7:0] c2;
    logic [7:0] c1;
    logic [7:0] c0;
  } pixel_t;

  // Source and destination spaces, source in the lowest bits
  typedef struct packed {
    space_t dst;
    space_t src;
  } sel_t;

  localparam int PIXEL_W = $bits(pixel_t);
  localparam int SEL_W   = $bits(sel_t);

endpackage

@@ rtl/csc_matrix.sv @@
// ----------------------------------------------------------------------------
// csc_matrix: color matrix and channel select
// Computes the forward and inverse BT.601 full-range matrices in fixed point,
// truncates toward zero, clips to 0..255 and picks the destination channels.
// ----------------------------------------------------------------------------
module csc_matrix #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  csc_pkg::sel_t   sel,
  input  csc_pkg::pixel_t pix_in,
  output csc_pkg::pixel_t pix_out
);
  import csc_pkg::*;

  localparam int F     = COEF_FRAC_BITS;
  localparam int CW    = F + 2;        // signed coefficient width, magnitudes below 2.0
  localparam int ACC_W = F + 11;       // holds a coefficient times a 9-bit signed value
  localparam longint ONE   = longint'(1) << F;
  localparam longint DEN   = 64'sd10000000;
  localparam longint HALF  = 64'sd5000000;

  // Coefficients in Q(F), rounded to nearest from units of 1e-7
  localparam longint K_YR = (64'sd2990000  * ONE + HALF) / DEN;
  localparam longint K_YG = (64'sd5870000  * ONE + HALF) / DEN;
  localparam longint K_YB = (64'sd1140000  * ONE + HALF) / DEN;
  localparam longint K_UR = (64'sd1687000  * ONE + HALF) / DEN;
  localparam longint K_UG = (64'sd3313000  * ONE + HALF) / DEN;
  localparam longint K_HF = (64'sd5000000  * ONE + HALF) / DEN;
  localparam longint K_VG = (64'sd4187000  * ONE + HALF) / DEN;
  localparam longint K_VB = (64'sd813000   * ONE + HALF) / DEN;
  localparam longint K_RU = (64'sd9267     * ONE + HALF) / DEN;
  localparam longint K_RV = (64'sd14016868 * ONE + HALF) / DEN;
  localparam longint K_GU = (64'sd3436954  * ONE + HALF) / DEN;
  localparam longint K_GV = (64'sd7141690  * ONE + HALF) / DEN;
  localparam longint K_BU = (64'sd17721604 * ONE + HALF) / DEN;
  localparam longint K_BV = (64'sd9902     * ONE + HALF) / DEN;

  localparam logic signed [CW-1:0] C_YR = CW'(K_YR);
  localparam logic signed [CW-1:0] C_YG = CW'(K_YG);
  localparam logic signed [CW-1:0] C_YB = CW'(K_YB);
  localparam logic signed [CW-1:0] C_UR = CW'(K_UR);
  localparam logic signed [CW-1:0] C_UG = CW'(K_UG);
  localparam logic signed [CW-1:0] C_HF = CW'(K_HF);
  localparam logic signed [CW-1:0] C_VG = CW'(K_VG);
  localparam logic signed [CW-1:0] C_VB = CW'(K_VB);
  localparam logic signed [CW-1:0] C_RU = CW'(K_RU);
  localparam logic signed [CW-1:0] C_RV = CW'(K_RV);
  localparam logic signed [CW-1:0] C_GU = CW'(K_GU);
  localparam logic signed [CW-1:0] C_GV = CW'(K_GV);
  localparam logic signed [CW-1:0] C_BU = CW'(K_BU);
  localparam logic signed [CW-1:0] C_BV = CW'(K_BV);

  localparam logic signed [ACC_W-1:0] OFS_128 = ACC_W'(longint'(128) * ONE);

  // Truncate toward zero and clip to 0..255; negative sums clip to zero
  function automatic logic [7:0] to_byte(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-F-1:0] whole;
    whole = acc[ACC_W-1:F];
    if (acc[ACC_W-1]) begin
      to_byte = 8'd0;
    end else if (whole > (ACC_W-F)'(255)) begin
      to_byte = 8'd255;
    end else begin
      to_byte = whole[7:0];
    end
  endfunction

  logic signed [8:0] s0, s1, s2, du, dv;
  logic signed [ACC_W-1:0] y_one;
  logic signed [ACC_W-1:0] p_yr, p_yg, p_yb, p_ur, p_ug, p_ub, p_vr, p_vg, p_vb;
  logic signed [ACC_W-1:0] p_ru, p_rv, p_gu, p_gv, p_bu, p_bv;
  logic [7:0] fy, fu, fv, ir, ig, ib;
  logic [7:0] r, g, b, a, y, u, v;

  // Channels as signed values, chroma centered on zero
  assign s0 = signed'({1'b0, pix_in.c0});
  assign s1 = signed'({1'b0, pix_in.c1});
  assign s2 = signed'({1'b0, pix_in.c2});
  assign du = s1 - 9'sd128;
  assign dv = s2 - 9'sd128;
  assign y_one = signed'(ACC_W'({pix_in.c0, F'(0)}));

  // Forward matrix products
  assign p_yr = C_YR * s0;
  assign p_yg = C_YG * s1;
  assign p_yb = C_YB * s2;
  assign p_ur = C_UR * s0;
  assign p_ug = C_UG * s1;
  assign p_ub = C_HF * s2;
  assign p_vr = C_HF * s0;
  assign p_vg = C_VG * s1;
  assign p_vb = C_VB * s2;

  // Inverse matrix products
  assign p_ru = C_RU * du;
  assign p_rv = C_RV * dv;
  assign p_gu = C_GU * du;
  assign p_gv = C_GV * dv;
  assign p_bu = C_BU * du;
  assign p_bv = C_BV * dv;

  // Sum, truncate and clip each channel
  assign fy = to_byte(p_yr + p_yg + p_yb);
  assign fu = to_byte(OFS_128 - p_ur - p_ug + p_ub);
  assign fv = to_byte(OFS_128 + p_vr - p_vg - p_vb);
  assign ir = to_byte(y_one - p_ru + p_rv);
  assign ig = to_byte(y_one - p_gu - p_gv);
  assign ib = to_byte(y_one + p_bu + p_bv);

  // Resolve all seven channels from the source space
  always_comb begin
    case (sel.src)
      SPACE_GREY: begin
        r = pix_in.c0; g = pix_in.c0; b = pix_in.c0; y = pix_in.c0;
        u = 8'd128;    v = 8'd128;    a = 8'd255;
      end
      SPACE_YUV: begin
        r = ir; g = ig; b = ib;
        y = pix_in.c0; u = pix_in.c1; v = pix_in.c2; a = 8'd255;
      end
      SPACE_RGBA: begin
        r = pix_in.c0; g = pix_in.c1; b = pix_in.c2; a = pix_in.c3;
        y = fy; u = fu; v = fv;
      end
      default: begin
        r = pix_in.c0; g = pix_in.c1; b = pix_in.c2; a = 8'd0;
        y = fy; u = fu; v = fv;
      end
    endcase
  end

  // Select the channels of the destination space, zero the unused ones
  always_comb begin
    pix_out = '0;
    case (sel.dst)
      SPACE_GREY: begin
        pix_out.c0 = y;
      end
      SPACE_YUV: begin
        pix_out.c0 = y; pix_out.c1 = u; pix_out.c2 = v;
      end
      SPACE_RGBA: begin
        pix_out.c0 = r; pix_out.c1 = g; pix_out.c2 = b; pix_out.c3 = a;
      end
      default: begin
        pix_out.c0 = r; pix_out.c1 = g; pix_out.c2 = b;
      end
    endcase
  end

endmodule

@@ rtl/color_space_converter_core.sv @@
// ----------------------------------------------------------------------------
// color_space_converter_core: pixel color space converter
// Converts one pixel color per item between grey, RGB, RGBA and full-range YUV.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one pixel color per item. s_tdata carries the four
//   source channels, s_tuser the source and destination space codes.
//   Master channel m_*: one converted color per item in m_tdata.
//   Every input item gives exactly one output item, in order.
// Path: the accepting edge loads the input register; the result register
//   takes the item from it as soon as the result register is free, and
//   m_tvalid rises with it, after which the item can leave.
// Throughput: one item per cycle while m_tready is high; the whole matrix,
//   clip and channel select sit between the input and result registers.
// Stall: while m_tready is low the result register holds its item; the input
//   register still takes one more item, and s_tready falls only when both
//   registers are full. A freed result register lets both stages advance in
//   the same cycle.
// Reset: rst clears both valid flags; no item is in flight afterwards.
// ----------------------------------------------------------------------------
module color_space_converter_core #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [csc_pkg::PIXEL_W-1:0]   s_tdata,   // in_c0, in_c1, in_c2, in_c3
  input  logic [csc_pkg::SEL_W-1:0]     s_tuser,   // src_space, dst_space
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [csc_pkg::PIXEL_W-1:0]   m_tdata    // out_c0, out_c1, out_c2, out_c3
);
  import csc_pkg::*;

  logic   in_valid;
  sel_t   in_sel;
  pixel_t in_pix;
  pixel_t conv_pix;
  pixel_t out_pix;
  logic   out_load;
  logic   in_load;

  // Advance when the next stage is empty or draining
  assign out_load = !m_tvalid || m_tready;
  assign s_tready = !in_valid || out_load;
  assign in_load  = s_tvalid && s_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_sel <= sel_t'(s_tuser);
      in_pix <= pixel_t'(s_tdata);
    end
  end

  // Conversion between the two registers
  csc_matrix #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_matrix (
    .sel     (in_sel),
    .pix_in  (in_pix),
    .pix_out (conv_pix)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid) begin
      out_pix <= conv_pix;
    end
  end

  assign m_tdata = out_pix;

  // Reset leaves both stages empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !in_valid && !m_tvalid)
    else $error("pipeline not empty after reset");

  // Input side stalls only with both stages full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid)
    else $error("input stalled with a free stage");

  // A loaded item shows up as a valid result
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    (out_load && in_valid) |=> m_tvalid)
    else $error("converted item lost");

  // A grey destination leaves the upper channels at zero
  a_grey_zero: assert property (@(posedge clk) disable iff (rst)
    (out_load && in_valid && in_sel.dst == SPACE_GREY) |=> m_tdata[31:8] == 24'd0)
    else $error("grey destination with nonzero upper channels");

endmodule

@@ tb/color_space_converter_checker.sv @@
// ----------------------------------------------------------------------------
// color_space_converter_checker: result checker for the color converter
// Watches both stream channels, predicts the converted color of every
// accepted input item and compares each output item against the oldest one.
// ----------------------------------------------------------------------------
module color_space_converter_checker #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [csc_pkg::PIXEL_W-1:0] s_tdata,   // in_c0, in_c1, in_c2, in_c3
  input  logic [csc_pkg::SEL_W-1:0]   s_tuser,   // src_space, dst_space
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [csc_pkg::PIXEL_W-1:0] m_tdata,   // out_c0, out_c1, out_c2, out_c3
  output int                          fail_count,
  output int                          pending,
  output int                          checked
);
  import csc_pkg::*;

  // Converted colors still owed by the block, oldest first
  pixel_t expected_colors[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  // Coefficient magnitude given in units of 1e-7, rounded to nearest in Q format
  function automatic longint coef_q(input longint unsigned mag);
    longint unsigned scaled;
    begin
      scaled = mag * (64'd1 << COEF_FRAC_BITS) + 64'd5000000;
      return longint'(scaled / 64'd10000000);
    end
  endfunction

  // Truncate toward zero, then clip to a byte; negative sums end at zero
  function automatic longint sum_to_byte(input longint acc);
    longint q;
    begin
      if (acc < 0) return 0;
      q = acc >>> COEF_FRAC_BITS;
      if (q > 255) return 255;
      return q;
    end
  endfunction

  // Predict the output color of one input item
  function automatic pixel_t convert_color(input logic [SEL_W-1:0] user,
                                           input logic [PIXEL_W-1:0] data);
    sel_t   sel;
    pixel_t px;
    pixel_t res;
    longint one;
    longint r, g, b, a, y, u, v, du, dv;
    begin
      sel = user;
      px  = data;
      one = longint'(1) << COEF_FRAC_BITS;
      case (sel.src)
        SPACE_GREY: begin
          y = px.c0;
          r = y;
          g = y;
          b = y;
          u = 128;
          v = 128;
          a = 255;
        end
        SPACE_YUV: begin
          y  = px.c0;
          u  = px.c1;
          v  = px.c2;
          du = u - 128;
          dv = v - 128;
          a  = 255;
          r  = sum_to_byte(y * one - coef_q(9267) * du + coef_q(14016868) * dv);
          g  = sum_to_byte(y * one - coef_q(3436954) * du - coef_q(7141690) * dv);
          b  = sum_to_byte(y * one + coef_q(17721604) * du + coef_q(9902) * dv);
        end
        default: begin
          r = px.c0;
          g = px.c1;
          b = px.c2;
          // plain rgb carries no alpha
          a = (sel.src == SPACE_RGBA) ? longint'(px.c3) : 0;
          y = sum_to_byte(coef_q(2990000) * r + coef_q(5870000) * g
                          + coef_q(1140000) * b);
          u = sum_to_byte(-coef_q(1687000) * r - coef_q(3313000) * g
                          + coef_q(5000000) * b + 128 * one);
          v = sum_to_byte(coef_q(5000000) * r - coef_q(4187000) * g
                          - coef_q(813000) * b + 128 * one);
        end
      endcase
      res = '0;
      case (sel.dst)
        SPACE_GREY: begin
          res.c0 = y[7:0];
        end
        SPACE_YUV: begin
          res.c0 = y[7:0];
          res.c1 = u[7:0];
          res.c2 = v[7:0];
        end
        default: begin
          res.c0 = r[7:0];
          res.c1 = g[7:0];
          res.c2 = b[7:0];
          if (sel.dst == SPACE_RGBA) res.c3 = a[7:0];
        end
      endcase
      return res;
    end
  endfunction

  // Print one error line and count it
  task automatic report_mismatch(input string what);
    begin
      $display("ERROR @%0t: %s", $time, what);
      fail_count++;
    end
  endtask

  // Compare output items first, then queue the prediction for a new input item
  always @(posedge clk) begin : watch_channels
    pixel_t     got;
    pixel_t     want;
    logic [3:0] bad;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_colors.size() == 0) begin
          report_mismatch($sformatf("output item %08h with no color pending", m_tdata));
        end else begin
          want = expected_colors.pop_front();
          got  = m_tdata;
          bad  = '0;
          for (int i = 0; i < 4; i++) begin
            if (got[8*i +: 8] !== want[8*i +: 8]) bad[i] = 1'b1;
          end
          if (bad != '0) begin
            report_mismatch($sformatf("color %0d: got %08h want %08h, wrong c3..c0 = %b",
                                      checked, got, want, bad));
          end
          checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        expected_colors.push_back(convert_color(s_tuser, s_tdata));
      end
      pending = expected_colors.size();
    end
  end

endmodule

@@ tb/tb_color_space_converter_core.sv @@
// ----------------------------------------------------------------------------
// tb_color_space_converter_core: testbench for the color space converter
// Drives directed and random pixel colors through every source/destination
// space pair with random stalls on both sides; a checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_color_space_converter_core;
  import csc_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int N_RANDOM    = 2000;
  localparam int QUIET_TAIL  = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [PIXEL_W-1:0] s_tdata;   // in_c0, in_c1, in_c2, in_c3
  logic [SEL_W-1:0]   s_tuser;   // src_space, dst_space
  logic               m_tvalid;
  logic               m_tready;
  logic [PIXEL_W-1:0] m_tdata;   // out_c0, out_c1, out_c2, out_c3

  int n_fail;
  int n_pending;
  int n_checked;
  int n_sent = 0;
  int cycles = 0;
  bit idle_on = 1'b1;

  color_space_converter_core #(
    .COEF_FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  color_space_converter_checker #(
    .COEF_FRAC_BITS(FRAC_BITS)
  ) color_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (n_fail),
    .pending    (n_pending),
    .checked    (n_checked)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d colors outstanding", cycles, n_pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: drop m_tready in random bursts while idling is enabled
  initial begin : drive_ready
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (idle_on && !rst && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(1, 3) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Present one color and hold it until accepted; returns at a falling edge
  task automatic send_color(input space_t src, input space_t dst,
                            input logic [7:0] c0, input logic [7:0] c1,
                            input logic [7:0] c2, input logic [7:0] c3);
    sel_t sel;
    begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      sel.src = src;
      sel.dst = dst;
      s_tvalid <= 1'b1;
      s_tuser  <= sel;
      s_tdata  <= {c3, c2, c1, c0};
      do @(posedge clk); while (!s_tready);
      n_sent++;
      @(negedge clk);
    end
  endtask

  // Random channel value, leaning toward the edges of the range now and then
  function automatic logic [7:0] pick_channel();
    begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0:       return 8'h00;
          1:       return 8'hFF;
          2:       return 8'h80;
          3:       return 8'h7F;
          4:       return 8'h01;
          default: return 8'hFE;
        endcase
      end
      return 8'($urandom_range(0, 255));
    end
  endfunction

  // Stimulus and verdict
  initial begin
    logic [7:0] v;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every source/destination pair, full-scale values included
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < 4; d++) begin
        v = 8'((4 * s + d) * 17);
        send_color(space_t'(s), space_t'(d), v, ~v, v ^ 8'hA5, 8'h5A);
      end
    end

    // Inverse matrix driven into both clip limits
    send_color(SPACE_YUV, SPACE_RGB, 8'hFF, 8'h00, 8'hFF, 8'h00);
    send_color(SPACE_YUV, SPACE_RGBA, 8'h00, 8'hFF, 8'h00, 8'hFF);
    send_color(SPACE_YUV, SPACE_RGB, 8'h00, 8'h00, 8'hFF, 8'h00);
    // Forward matrix at white and black
    send_color(SPACE_RGB, SPACE_YUV, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_color(SPACE_RGBA, SPACE_YUV, 8'h00, 8'h00, 8'h00, 8'hFF);
    // Alpha pass-through at both ends, and rgb without alpha into rgba
    send_color(SPACE_RGBA, SPACE_RGBA, 8'h12, 8'h34, 8'h56, 8'h00);
    send_color(SPACE_RGBA, SPACE_RGBA, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_color(SPACE_RGB, SPACE_RGBA, 8'h80, 8'h40, 8'h20, 8'hFF);
    // Grey ignores its other channels
    send_color(SPACE_GREY, SPACE_RGBA, 8'h37, 8'hFF, 8'hFF, 8'hFF);

    // Random colors: idling in phases, none in the tail
    for (int i = 0; i < N_RANDOM; i++) begin
      idle_on = (i < N_RANDOM - QUIET_TAIL) && ((i / 250) % 3 != 2);
      send_color(space_t'($urandom_range(0, 3)), space_t'($urandom_range(0, 3)),
                 pick_channel(), pick_channel(), pick_channel(), pick_channel());
    end
    s_tvalid <= 1'b0;

    // Drain, then keep the clock running for anything stray
    while (n_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d pixel colors over all 16 space pairs, checked %0d converted colors,",
             n_sent, n_checked);
    $display("with clip limits, alpha handling and random stalls on both channels.");
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors", n_fail);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
